// ===== sv/sorted_set_union_merge_assert.svh =====
// Assertion macros for the sorted set union merge block, used by its top file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SORTED_SET_UNION_MERGE_ASSERT_SVH
`define SORTED_SET_UNION_MERGE_ASSERT_SVH

// The property holds at every rising clock edge outside reset.
`define SSUM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSUM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ssum_pkg.sv =====
`default_nettype none

package ssum_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int VALUE_BITS = 31;
  localparam int POS_W      = 6;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_START       = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [VALUE_BITS-1:0] element;
  } ssum_in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] merged_value;
    logic [POS_W-1:0]      position;
    logic                  last;
    logic                  empty_res;
    logic                  overflowed;
  } ssum_out_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
  } ssum_cmd_t;

  typedef struct packed {
    logic both_empty;
    logic last_elem;
    logic out_ready;
  } ssum_status_t;

endpackage

`default_nettype wire

// ===== sv/ssum_ctrl.sv =====
`default_nettype none

module ssum_ctrl import ssum_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   in_cmd_i,
  output logic         in_stall_o,
  input  ssum_status_t status_i,
  output ssum_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = 1'b1;
    if (state_q == ST_IDLE) begin
      in_stall_o = (in_cmd_i == CMD_START) && !status_i.out_ready;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_LOAD_FIRST:  cmd_o.load_a = 1'b1;
            CMD_LOAD_SECOND: cmd_o.load_b = 1'b1;
            CMD_START: begin
              cmd_o.start = 1'b1;
              if (!status_i.both_empty) begin
                state_d = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_ready) begin
          cmd_o.step = 1'b1;
          state_d    = status_i.last_elem ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssum_datapath.sv =====
`default_nettype none

module ssum_datapath import ssum_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssum_cmd_t             cmd_i,
  input  logic [VALUE_BITS-1:0] element_i,
  input  logic                  out_stall_i,
  output ssum_status_t          status_o,
  output logic                  out_valid_o,
  output ssum_out_t             out_o
);

  logic [VALUE_BITS-1:0] mem_a [LIST_DEPTH];
  logic [VALUE_BITS-1:0] mem_b [LIST_DEPTH];
  logic [VALUE_BITS-1:0] rd_a_q, rd_b_q;

  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [CNT_W-1:0] ptr_a_nxt, ptr_b_nxt;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             drop_q, drop_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  ssum_out_t        out_q, out_d;

  logic full_a, full_b, avail_a, avail_b, take_a, take_b, last_elem, out_ready;

  assign full_a  = (cnt_a_q == CNT_W'(LIST_DEPTH));
  assign full_b  = (cnt_b_q == CNT_W'(LIST_DEPTH));
  assign avail_a = (ptr_a_q < cnt_a_q);
  assign avail_b = (ptr_b_q < cnt_b_q);
  assign take_a  = avail_a && (!avail_b || (rd_a_q <= rd_b_q));
  assign take_b  = avail_b && (!avail_a || (rd_b_q <= rd_a_q));

  assign ptr_a_nxt = ptr_a_q + CNT_W'(take_a);
  assign ptr_b_nxt = ptr_b_q + CNT_W'(take_b);
  assign last_elem = (ptr_a_nxt >= cnt_a_q) && (ptr_b_nxt >= cnt_b_q);
  assign out_ready = !out_valid_q || !out_stall_i;

  assign status_o.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign status_o.last_elem  = last_elem;
  assign status_o.out_ready  = out_ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !full_a) begin
      mem_a[cnt_a_q[PTR_W-1:0]] <= element_i;
    end
    if (cmd_i.load_b && !full_b) begin
      mem_b[cnt_b_q[PTR_W-1:0]] <= element_i;
    end
    rd_a_q <= mem_a[ptr_a_q[PTR_W-1:0]];
    rd_b_q <= mem_b[ptr_b_q[PTR_W-1:0]];
  end

  always_comb begin
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ptr_a_d     = ptr_a_q;
    ptr_b_d     = ptr_b_q;
    pos_d       = pos_q;
    drop_d      = drop_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cmd_i.load_a) begin
      if (full_a) begin
        drop_d = 1'b1;
      end else begin
        cnt_a_d = cnt_a_q + CNT_W'(1);
      end
    end
    if (cmd_i.load_b) begin
      if (full_b) begin
        drop_d = 1'b1;
      end else begin
        cnt_b_d = cnt_b_q + CNT_W'(1);
      end
    end

    if (cmd_i.start) begin
      ovf_d  = drop_q;
      drop_d = 1'b0;
      pos_d  = '0;
      if (status_o.both_empty) begin
        out_valid_d        = 1'b1;
        out_d.merged_value = '0;
        out_d.position     = '0;
        out_d.last         = 1'b0;
        out_d.empty_res    = 1'b1;
        out_d.overflowed   = drop_q;
      end
    end

    if (cmd_i.step) begin
      out_valid_d        = 1'b1;
      out_d.merged_value = take_a ? rd_a_q : rd_b_q;
      out_d.position     = pos_q;
      out_d.last         = last_elem;
      out_d.empty_res    = 1'b0;
      out_d.overflowed   = ovf_q;
      pos_d              = pos_q + POS_W'(1);
      if (last_elem) begin
        cnt_a_d = '0;
        cnt_b_d = '0;
        ptr_a_d = '0;
        ptr_b_d = '0;
      end else begin
        ptr_a_d = ptr_a_nxt;
        ptr_b_d = ptr_b_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      pos_q       <= pos_d;
      drop_q      <= drop_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== sv/sorted_set_union_merge.sv =====
// Sorted set union merge.
// The input channel (in_valid_i, in_stall_o, in_i) carries one transaction per
// command: load an element into the first or the second list, or start a merge.
// Each list holds up to 32 elements; a load into a full list is dropped and
// sets the overflow flag, which is reported on every result of the next merge.
// A start sends the ascending union out on the output channel (out_valid_o,
// out_stall_i, out_o), one transaction per element with its position and a last
// mark, or a single result marked empty when both lists are empty.
// A merge alternates between the emit and fetch states, as the list memories
// are read through a register, and the input is stalled until the
// final element has been placed in the output register. A start leads straight to
// the emit state; an empty merge is answered in the cycle after the start.
// The result register lets loads proceed while the last result waits; a start
// is stalled while an earlier result is still held by the receiver.
// When the receiver stalls, the result holds and the merge waits for it.
// Reset empties both lists and clears the overflow flag.
`default_nettype none

`include "sorted_set_union_merge_assert.svh"

module sorted_set_union_merge import ssum_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ssum_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssum_out_t out_o
);

  ssum_cmd_t    dp_cmd;
  ssum_status_t dp_status;

  ssum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ssum_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .element_i   (in_i.element),
    .out_stall_i (out_stall_i),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  `SSUM_ASSERT(a_step_stalls_input, !dp_cmd.step || in_stall_o, "merge step while input open")
  `SSUM_ASSERT_NEXT(a_step_gives_result, dp_cmd.step, out_valid_o, "merge step lost result")
  `SSUM_ASSERT(a_empty_result_shape,
               !(out_valid_o && out_o.empty_res) || (out_o.position == '0 && !out_o.last),
               "empty result with element fields")

endmodule

`default_nettype wire
